/* hw/rtl/tilt_complementary_filter_unit_defines.svh */
// Assertion macros shared by the RTL.
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence on the same edge.
`define TCF_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define TCF_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tcf_pkg.sv */
package tcf_pkg;

	localparam int unsigned TableLen = 24;
	localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
	localparam logic signed [35:0] TwoPiQ30 = 36'sd6746518852;
	localparam logic [21:0] Deg573Q16 = 22'd3755213;
	localparam logic [21:0] Rad2DegQ16 = 22'd3754936;

	// Configuration register indexes.
	localparam logic [0:0] RegGyroGain = 1'b0;
	localparam logic [0:0] RegBlendWeight = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_C_INIT,
		ST_C_ITER,
		ST_DEG_MUL,
		ST_DEG_WAIT,
		ST_DEG_RND,
		ST_PROP,
		ST_BLEND_A,
		ST_BLEND_B,
		ST_BLEND_C,
		ST_DONE
	} state_t;

	// Which angle the shared CORDIC is working on.
	typedef enum logic [1:0] {
		JOB_ROLL,
		JOB_PITCH,
		JOB_HEAD
	} job_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd843314857;
			5'd1: v = 32'd497837829;
			5'd2: v = 32'd263043837;
			5'd3: v = 32'd133525159;
			5'd4: v = 32'd67021687;
			5'd5: v = 32'd33543516;
			5'd6: v = 32'd16775851;
			5'd7: v = 32'd8388437;
			5'd8: v = 32'd4194283;
			5'd9: v = 32'd2097149;
			default: v = 32'd1 << (5'd30 - i);
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/tilt_complementary_filter_unit.sv */
// Tilt complementary filter. Each sample word on the input channel yields
// one result word with filtered roll, pitch (signed) and compass heading
// (0 to below 360 degrees), all in units of 2^-ANGLE_FRAC_BITS degree.
// All math runs on one shared CORDIC vectoring unit, one bit-pair-per-cycle
// square root and one shared multiplier, under a sequencer that runs three
// CORDIC passes (roll, then pitch after the root, then heading). The input is
// stalled while a sample is in work; a finished result sits in an output
// register so the next sample can be taken while it waits, and the sequencer
// holds its next result until that register is free. gyro_gain and
// blend_weight must be written through the config port only while the block
// is idle; the block itself does not enforce this.
`include "tilt_complementary_filter_unit_defines.svh"

module tilt_complementary_filter_unit #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] field_x,
	input  logic signed [15:0] field_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] roll_out,
	output logic signed [23:0] pitch_out,
	output logic        [16:0] heading_out,
	input  logic               cfg_we,
	input  logic        [0:0]  cfg_index,
	input  logic        [15:0] cfg_data
);
	import tcf_pkg::*;

	localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
	localparam int DegShift = 46 - ANGLE_FRAC_BITS;
	localparam int GyroShift = 16 - ANGLE_FRAC_BITS;
	localparam logic signed [31:0] FullTurn = 32'sd360 <<< ANGLE_FRAC_BITS;

	state_t state_q, state_d;
	job_t   job_q;

	logic [15:0] gain_q, weight_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, mx_q, my_q;
	logic signed [23:0] roll_q, pitch_q;
	logic        [16:0] head_q;
	logic               out_valid_q;
	logic signed [23:0] roll_res_q, pitch_res_q;
	logic        [16:0] head_res_q;

	// Square root state: 64-bit radicand, floor root.
	logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [31:0] root_q;

	// CORDIC registers (operands are 16-bit values scaled by 2^16, plus growth).
	logic signed [35:0] cx_q, cy_q, cz_q;
	logic [4:0]         step_q;

	// Shared multiplier operands and registered product.
	logic signed [36:0] ma_q;
	logic signed [22:0] mb_q;
	logic signed [59:0] prod_s1;
	logic signed [59:0] acc_q;
	logic signed [31:0] tilt_q;

	logic in_fire, out_fire, busy, res_load;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign busy     = (state_q != ST_IDLE);
	assign in_stall = busy;
	assign res_load = (state_q == ST_DONE) && (!out_valid_q || out_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 16'd999;
			weight_q <= 16'd52429;
		end else if (cfg_we) begin
			case (cfg_index)
				RegGyroGain:    gain_q <= cfg_data;
				RegBlendWeight: weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Combinational helpers.
	logic [63:0] sq_trial;
	logic signed [35:0] dx, dy;
	logic signed [35:0] atab;
	logic signed [59:0] rnd_val;
	logic signed [59:0] deg_rnd;
	logic signed [31:0] deg_v;
	logic signed [31:0] sat_p;
	logic signed [59:0] blend_rnd;
	logic signed [31:0] blend_sat;

	assign sq_trial = sq_res_q + sq_bit_q;
	assign dx = cy_q >>> step_q;
	assign dy = cx_q >>> step_q;
	assign atab = $signed({4'd0, atan_entry(step_q)});
	assign deg_rnd = (prod_s1 + (60'sd1 <<< (DegShift - 1))) >>> DegShift;
	assign deg_v = deg_rnd[31:0];
	assign rnd_val = (prod_s1 + (60'sd1 <<< (GyroShift - 1))) >>> GyroShift;
	// The gyro-weighted term sits in acc_q, the tilt-weighted term in the product.
	assign blend_rnd = (acc_q + prod_s1 + 60'sd32768) >>> 16;

	function automatic logic signed [31:0] sat24(input logic signed [59:0] v);
		logic signed [31:0] r;
		if (v > 60'sd8388607) r = 32'sd8388607;
		else if (v < -60'sd8388608) r = -32'sd8388608;
		else r = v[31:0];
		return r;
	endfunction

	assign sat_p = sat24(rnd_val + 60'(job_q == JOB_ROLL ? roll_q : pitch_q));
	assign blend_sat = sat24(blend_rnd);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_fire) state_d = ST_C_INIT;
			ST_SQRT:     if (sq_bit_q == 64'd0) state_d = ST_C_INIT;
			ST_C_INIT:   state_d = ST_C_ITER;
			ST_C_ITER:   if (step_q == 5'(Steps - 1)) state_d = ST_DEG_MUL;
			ST_DEG_MUL:  state_d = ST_DEG_WAIT;
			ST_DEG_WAIT: state_d = ST_DEG_RND;
			ST_DEG_RND:  state_d = (job_q == JOB_HEAD) ? ST_DONE : ST_PROP;
			ST_PROP:     state_d = ST_BLEND_A;
			ST_BLEND_A:  state_d = ST_BLEND_B;
			ST_BLEND_B:  state_d = ST_BLEND_C;
			ST_BLEND_C:  state_d = (job_q == JOB_ROLL) ? ST_SQRT : ST_C_INIT;
			ST_DONE:     if (res_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_ROLL;
			roll_q      <= '0;
			pitch_q     <= '0;
			out_valid_q <= 1'b0;
			roll_res_q  <= '0;
			pitch_res_q <= '0;
			head_res_q  <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
				roll_res_q  <= roll_q;
				pitch_res_q <= pitch_q;
				head_res_q  <= head_q;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_fire) job_q <= JOB_ROLL;
				ST_BLEND_C: begin
					if (job_q == JOB_ROLL) begin
						roll_q <= blend_sat[23:0];
						job_q  <= JOB_PITCH;
					end else begin
						pitch_q <= blend_sat[23:0];
						job_q   <= JOB_HEAD;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	logic signed [35:0] ox, oy;
	always_comb begin
		case (job_q)
			JOB_ROLL: begin
				oy = 36'(ay_q) <<< 16;
				ox = 36'(az_q) <<< 16;
			end
			JOB_PITCH: begin
				oy = -(36'(ax_q) <<< 16);
				ox = $signed({4'd0, root_q});
			end
			default: begin
				oy = 36'(my_q) <<< 16;
				ox = 36'(mx_q) <<< 16;
			end
		endcase
	end

	logic signed [35:0] hz;
	always_comb begin
		hz = cz_q;
		if (hz < 0) hz = hz + TwoPiQ30;
		if (hz > TwoPiQ30) hz = hz - TwoPiQ30;
	end

	logic signed [31:0] head_v;
	always_comb begin
		head_v = deg_v;
		if (head_v >= FullTurn) head_v = head_v - FullTurn;
		if (head_v < 0) head_v = '0;
	end

	logic zero_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				ax_q <= accel_x; ay_q <= accel_y; az_q <= accel_z;
				gx_q <= rate_x;  gy_q <= rate_y;
				mx_q <= field_x; my_q <= field_y;
			end
			ST_BLEND_C: if (job_q == JOB_ROLL) begin
				sq_n_q   <= 64'(32'(ay_q * ay_q) + 32'(az_q * az_q)) << 32;
				sq_res_q <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			ST_SQRT: if (sq_bit_q != 64'd0) begin
				if (sq_n_q >= sq_trial) begin
					sq_n_q   <= sq_n_q - sq_trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end else begin
				root_q <= sq_res_q[31:0];
			end
			ST_C_INIT: begin
				step_q <= '0;
				zero_q <= (ox == 0) && (oy == 0);
				if (ox < 0) begin
					cz_q <= (oy >= 0) ? PiQ30 : -PiQ30;
					cx_q <= -ox;
					cy_q <= -oy;
				end else begin
					cz_q <= '0;
					cx_q <= ox;
					cy_q <= oy;
				end
			end
			ST_C_ITER: begin
				step_q <= step_q + 5'd1;
				if (cy_q >= 0) begin
					cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + atab;
				end else begin
					cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - atab;
				end
			end
			ST_DEG_MUL: begin
				if (job_q == JOB_HEAD) begin
					ma_q <= zero_q ? '0 : 37'(hz);
					mb_q <= $signed({1'b0, Rad2DegQ16});
				end else begin
					ma_q <= zero_q ? '0 : 37'(cz_q);
					mb_q <= $signed({1'b0, Deg573Q16});
				end
			end
			// The degree product is formed here; the gyro operands follow behind it.
			ST_DEG_WAIT: begin
				ma_q <= 37'(job_q == JOB_ROLL ? gx_q : gy_q);
				mb_q <= $signed({7'd0, gain_q});
			end
			ST_DEG_RND: begin
				if (job_q == JOB_HEAD) head_q <= head_v[16:0];
				else tilt_q <= -deg_v;
			end
			ST_PROP: begin
				ma_q <= 37'(sat_p);
				mb_q <= $signed({7'd0, weight_q});
			end
			ST_BLEND_A: begin
				ma_q <= 37'(tilt_q);
				mb_q <= 23'sd65536 - $signed({7'd0, weight_q});
			end
			ST_BLEND_B: acc_q <= prod_s1;
			default: ;
		endcase
	end

	// Single shared multiplier with a registered product.
	always_ff @(posedge clk) begin
		prod_s1 <= ma_q * mb_q;
	end

	assign out_valid   = out_valid_q;
	assign roll_out    = roll_res_q;
	assign pitch_out   = pitch_res_q;
	assign heading_out = head_res_q;

	`TCF_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, busy, in_stall, "input taken while busy")
	`TCF_ASSERT_NEXT(a_done_sets_valid, clk, arst_n, state_q == ST_DONE && !out_valid_q, out_valid_q, "result lost")
	`TCF_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_fire, state_q == ST_C_INIT && job_q == JOB_ROLL, "sequencer did not start")

endmodule

/* sim/tilt_complementary_filter_unit_checker.sv */
`timescale 1ns / 1ps

module tilt_complementary_filter_unit_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] field_x,
	input  logic signed [15:0] field_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [23:0] roll_out,
	input  logic signed [23:0] pitch_out,
	input  logic        [16:0] heading_out,
	input  logic               cfg_we,
	input  logic        [0:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);
	import tcf_pkg::*;

	localparam int STEPS = 16;
	localparam int FRAC = 8;
	localparam longint S24_HI = 64'sd8388607;
	localparam longint S24_LO = -64'sd8388608;

	typedef struct packed {
		logic [23:0] roll;
		logic [23:0] pitch;
		logic [16:0] heading;
	} attitude_t;

	longint atan_rom [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};

	logic [15:0] gain_q16;
	logic [15:0] weight_q16;
	longint roll_acc;
	longint pitch_acc;
	attitude_t expected_q[$];

	function automatic longint round_shift(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp24(longint v);
		if (v > S24_HI) return S24_HI;
		if (v < S24_LO) return S24_LO;
		return v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_rom[i];
			end else begin
				x -= dx; y += dy; z -= atan_rom[i];
			end
		end
		return z;
	endfunction

	function automatic longint to_degrees(longint rad, longint factor);
		return round_shift(rad * factor, 46 - FRAC);
	endfunction

	function automatic longint blend_axis(longint angle, longint rate, longint tilt);
		longint w;
		longint p;
		w = longint'(weight_q16);
		p = clamp24(angle + round_shift(rate * longint'(gain_q16), 16 - FRAC));
		return clamp24(round_shift(w * p + (65536 - w) * tilt, 16));
	endfunction

	function automatic attitude_t filter_sample();
		longint ax, ay, az, mx, my, roll_tilt, pitch_tilt, hrad, head;
		longint unsigned mag;
		attitude_t r;
		ax = accel_x; ay = accel_y; az = accel_z;
		mx = field_x; my = field_y;
		roll_tilt = -to_degrees(vector_angle(ay * 65536, az * 65536), longint'(Deg573Q16));
		mag = int_root(longint'(ay * ay + az * az) << 32);
		pitch_tilt = -to_degrees(vector_angle(-ax * 65536, longint'(mag)),
			longint'(Deg573Q16));
		roll_acc = blend_axis(roll_acc, longint'(rate_x), roll_tilt);
		pitch_acc = blend_axis(pitch_acc, longint'(rate_y), pitch_tilt);
		hrad = vector_angle(my * 65536, mx * 65536);
		if (hrad < 0) hrad += longint'(TwoPiQ30);
		if (hrad > longint'(TwoPiQ30)) hrad -= longint'(TwoPiQ30);
		head = to_degrees(hrad, longint'(Rad2DegQ16));
		if (head >= (64'sd360 <<< FRAC)) head -= (64'sd360 <<< FRAC);
		if (head < 0) head = 0;
		r.roll = roll_acc[23:0];
		r.pitch = pitch_acc[23:0];
		r.heading = head[16:0];
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		attitude_t e;
		if (!arst_n) begin
			gain_q16 <= 16'd999;
			weight_q16 <= 16'd52429;
			roll_acc = 0;
			pitch_acc = 0;
			expected_q.delete();
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegGyroGain) gain_q16 <= cfg_data;
				else if (cfg_index == RegBlendWeight) weight_q16 <= cfg_data;
			end
			if (in_valid && !in_stall) expected_q.push_back(filter_sample());
			if (out_valid && !out_stall) begin
				checked <= checked + 1;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("result word with nothing expected: %0d %0d %0d",
							roll_out, pitch_out, heading_out);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.roll !== roll_out || e.pitch !== pitch_out
							|| e.heading !== heading_out) begin
						if (fail_count < 10)
							$display("mismatch: roll %0d/%0d pitch %0d/%0d heading %0d/%0d",
								$signed(e.roll), roll_out, $signed(e.pitch), pitch_out,
								e.heading, heading_out);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* sim/tilt_complementary_filter_unit_tb.sv */
`timescale 1ns / 1ps

module tilt_complementary_filter_unit_tb;
	import tcf_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] accel_x, accel_y, accel_z, rate_x, rate_y, field_x, field_y;
	logic out_valid;
	logic out_stall;
	logic signed [23:0] roll_out, pitch_out;
	logic [16:0] heading_out;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;
	int fail_count, pending, checked;
	int send_idle, recv_idle, quiet_cycles, samples;

	tilt_complementary_filter_unit DUT (.*);
	tilt_complementary_filter_unit_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, mx, my);
		in_valid <= 1'b1;
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		rate_x <= gx; rate_y <= gy; field_x <= mx; field_y <= my;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		samples++;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rnd_field();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(200)) - 100);
			2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(8000)) - 4000);
		endcase
	endfunction

	task automatic random_phase(input int n);
		for (int k = 0; k < n; k++)
			send_sample(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
				rnd_field(), rnd_field());
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		{accel_x, accel_y, accel_z, rate_x, rate_y, field_x, field_y} = '0;
		send_idle = 0;
		recv_idle = 0;
		quiet_cycles = 0;
		samples = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed words at reset settings: all-zero vectors, extremes, heading wrap.
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h8000, 0, 16'h7fff, 0, 0, 16'h8000, 0);
		send_sample(0, 16'h8000, 0, 0, 0, 16'h8000, 16'hffff);
		send_sample(100, 0, 0, 5, -16'sd5, 16'h7fff, 16'hffff);
		send_sample(-16'sd100, 0, 0, 0, 0, 0, 16'h8000);
		send_sample(0, 0, 16'h8000, 0, 0, 0, 16'h7fff);
		send_sample(0, 1, 0, 0, 0, 1, 0);
		send_sample(0, 0, 0, 0, 0, 16'hffff, 0);
		drain();
		// Full gain and full gyro weight drive both angles into saturation.
		write_reg(RegGyroGain, 16'hffff);
		write_reg(RegBlendWeight, 16'hffff);
		repeat (5) send_sample(0, 0, 1000, 16'h7fff, 16'h8000, 1, 1);
		repeat (5) send_sample(0, 0, 1000, 16'h8000, 16'h7fff, 1, 1);
		drain();
		write_reg(RegGyroGain, 16'h0000);
		write_reg(RegBlendWeight, 16'h0000);
		repeat (3) send_sample(16'h1234, 16'hedcb, 16'h4000, 16'h7fff, 16'h8000, 3, -16'sd3);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 29 : (ph == 1) ? 67 : 0;
			recv_idle = (ph == 0) ? 67 : (ph == 1) ? 29 : 0;
			write_reg(RegGyroGain, 16'($urandom));
			write_reg(RegBlendWeight, (ph == 2) ? 16'd52429 : 16'($urandom));
			random_phase(300);
			drain();
			write_reg(RegGyroGain, 16'($urandom_range(3000)));
			write_reg(RegBlendWeight, 16'($urandom_range(40000, 65535)));
			random_phase(130);
			drain();
		end
		in_valid <= 0;
		drain();

		$display("Sent %0d sensor words over three idle profiles and several gain/weight",
			samples);
		$display("settings; %0d result words compared.", checked);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
